// ===== design/bsp_pkg.sv =====
// package: shared types, constants and tables of the box support-point unit
`timescale 1ns / 1ps
`default_nettype none
package bsp_pkg;

	localparam int CORNER_COUNT    = 8;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int IN_WIDTH        = 32;
	localparam int CORNER_BITS     = $clog2(CORNER_COUNT);

	// command codes
	localparam logic [2:0] CMD_RESET_BOUNDS = 3'd0;
	localparam logic [2:0] CMD_VERTEX       = 3'd1;
	localparam logic [2:0] CMD_BUILD        = 3'd2;
	localparam logic [2:0] CMD_MATRIX_ROW   = 3'd3;
	localparam logic [2:0] CMD_TRANSFORM    = 3'd4;
	localparam logic [2:0] CMD_SUPPORT      = 3'd5;

	localparam logic [1:0] ROW_LAST  = 2'd2;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef struct packed {
		logic [2:0]                  cmd;
		logic [1:0]                  row_sel;
		logic signed [IN_WIDTH-1:0] val_a;
		logic signed [IN_WIDTH-1:0] val_b;
		logic signed [IN_WIDTH-1:0] val_c;
		logic signed [IN_WIDTH-1:0] val_d;
	} req_t;

	typedef struct packed {
		logic [2:0]                  best_index;
		logic signed [IN_WIDTH-1:0] point_x;
		logic signed [IN_WIDTH-1:0] point_y;
		logic signed [IN_WIDTH-1:0] point_z;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic                   load;
		logic                   mul_en;
		logic                   acc_init;
		logic                   fin;
		logic                   is_query;
		logic [CORNER_BITS-1:0] k;
		logic [1:0]             r;
		logic [1:0]             i;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_pending;
	} stat_t;

	// extended axes per corner: bit0 x, bit1 y, bit2 z
	function automatic logic [2:0] corner_axes(input logic [CORNER_BITS-1:0] k);
		logic [2:0] m;
		unique case (k)
			3'd0: m = 3'b000;
			3'd1: m = 3'b001;
			3'd2: m = 3'b010;
			3'd3: m = 3'b100;
			3'd4: m = 3'b011;
			3'd5: m = 3'b101;
			3'd6: m = 3'b110;
			3'd7: m = 3'b111;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== design/bsp_stream_if.sv =====
// interface: valid/ready channel carrying one payload
`timescale 1ns / 1ps
`default_nettype none
interface bsp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/bsp_datapath.sv =====
// datapath: bounds, corners, matrix, shared multiply-accumulate, result register
`timescale 1ns / 1ps
`default_nettype none
module bsp_datapath import bsp_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req_data,
	input  wire ctl_t ctl,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data,
	output logic      rsp_valid,
	output stat_t     stat
);

	localparam int CW = COORD_WIDTH;
	localparam int IW = IN_WIDTH;
	localparam int EW = ((CW > IW) ? CW : IW) + 1;
	localparam int PW = IW + CW;
	localparam int AW = PW + 2;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [IW-1:0] ONE  = IW'(1) << FRAC_BITS;

	logic signed [IW-1:0] in_v [4];
	logic signed [CW-1:0] vsat [3];
	logic signed [CW-1:0] ext_v [3];

	logic signed [CW-1:0] box_min_q [3];
	logic signed [CW-1:0] box_max_q [3];
	logic signed [CW-1:0] lc_min_q [3];
	logic signed [CW-1:0] lc_ext_q [3];
	logic signed [IW-1:0] mat_q [3][3];
	logic signed [IW-1:0] trans_q [3];
	logic signed [IW-1:0] dir_q [3];
	logic signed [CW-1:0] world_q [CORNER_COUNT][3];
	logic signed [CW-1:0] cur_q [3];
	logic signed [CW-1:0] best_pt_q [3];
	logic [CORNER_BITS-1:0] best_idx_q;
	logic signed [AW-1:0] best_dot_q;
	logic signed [AW-1:0] acc_q;
	logic signed [PW-1:0] prod_s1;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [2:0]           ax_m;
	logic signed [IW-1:0] op_a;
	logic signed [CW-1:0] op_b;
	logic signed [CW-1:0] lc_val;
	logic signed [AW-1:0] term;
	logic signed [AW-1:0] init_v;
	logic signed [AW-1:0] final_v;
	logic signed [CW-1:0] final_sat;
	logic                 take;
	logic signed [CW-1:0] out_pt [3];
	logic signed [EW-1:0] out_ext [3];

	assign in_v[0] = req_data.val_a;
	assign in_v[1] = req_data.val_b;
	assign in_v[2] = req_data.val_c;
	assign in_v[3] = req_data.val_d;

	// input saturation and corner extent per axis
	always_comb begin
		logic signed [EW-1:0] ev;
		logic signed [CW:0]   d;
		logic signed [CW:0]   ad;
		logic signed [CW+1:0] s;
		for (int a = 0; a < 3; a++) begin
			ev = EW'(in_v[a]);
			if (ev > EW'(CMAX)) begin
				vsat[a] = CMAX;
			end else if (ev < EW'(CMIN)) begin
				vsat[a] = CMIN;
			end else begin
				vsat[a] = ev[CW-1:0];
			end
			d  = (CW+1)'(box_max_q[a]) - (CW+1)'(box_min_q[a]);
			ad = (d < 0) ? -d : d;
			s  = (CW+2)'(box_min_q[a]) + (CW+2)'(ad);
			if (s > (CW+2)'(CMAX)) begin
				ext_v[a] = CMAX;
			end else begin
				ext_v[a] = s[CW-1:0];
			end
		end
	end

	// simple commands on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min_q[a] <= CMAX;
				box_max_q[a] <= CMIN;
				lc_min_q[a]  <= '0;
				lc_ext_q[a]  <= '0;
				trans_q[a]   <= '0;
				for (int j = 0; j < 3; j++) begin
					mat_q[a][j] <= (a == j) ? ONE : '0;
				end
			end
		end else if (ctl.load) begin
			unique case (req_data.cmd)
				CMD_RESET_BOUNDS: begin
					for (int a = 0; a < 3; a++) begin
						box_min_q[a] <= CMAX;
						box_max_q[a] <= CMIN;
					end
				end
				CMD_VERTEX: begin
					for (int a = 0; a < 3; a++) begin
						if (vsat[a] > box_max_q[a]) box_max_q[a] <= vsat[a];
						if (vsat[a] < box_min_q[a]) box_min_q[a] <= vsat[a];
					end
				end
				CMD_BUILD: begin
					for (int a = 0; a < 3; a++) begin
						lc_min_q[a] <= box_min_q[a];
						lc_ext_q[a] <= ext_v[a];
					end
				end
				CMD_MATRIX_ROW: begin
					if (req_data.row_sel <= ROW_LAST) begin
						for (int j = 0; j < 3; j++) begin
							mat_q[req_data.row_sel][j] <= in_v[j];
						end
						trans_q[req_data.row_sel] <= in_v[3];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && req_data.cmd == CMD_SUPPORT) begin
			for (int a = 0; a < 3; a++) dir_q[a] <= in_v[a];
		end
	end

	// operand select and shared multiplier
	always_comb begin
		ax_m   = corner_axes(ctl.k);
		lc_val = ax_m[ctl.i] ? lc_ext_q[ctl.i] : lc_min_q[ctl.i];
		op_a   = ctl.is_query ? dir_q[ctl.i] : mat_q[ctl.r][ctl.i];
		op_b   = ctl.is_query ? world_q[ctl.k][ctl.i] : lc_val;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PW'(op_a) * PW'(op_b);
			if (ctl.is_query) cur_q[ctl.i] <= op_b;
		end
	end

	always_comb begin
		term      = ctl.is_query ? AW'(prod_s1) : AW'(prod_s1 >>> FRAC_BITS);
		init_v    = ctl.is_query ? '0 : AW'(trans_q[ctl.r]);
		final_v   = acc_q + term;
		if (final_v > AW'(CMAX)) begin
			final_sat = CMAX;
		end else if (final_v < AW'(CMIN)) begin
			final_sat = CMIN;
		end else begin
			final_sat = final_v[CW-1:0];
		end
		take = (ctl.k == '0) || (final_v > best_dot_q);
		for (int a = 0; a < 3; a++) begin
			out_pt[a]  = take ? cur_q[a] : best_pt_q[a];
			out_ext[a] = EW'(out_pt[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_init) begin
			acc_q <= init_v;
		end else if (ctl.mul_en) begin
			acc_q <= final_v;
		end
		if (ctl.fin && ctl.is_query && take) begin
			best_dot_q <= final_v;
			best_idx_q <= ctl.k;
			best_pt_q  <= cur_q;
		end
		if (ctl.fin && ctl.is_query && ctl.k == CORNER_BITS'(CORNER_COUNT-1)) begin
			rsp_q.best_index <= take ? ctl.k : best_idx_q;
			rsp_q.point_x    <= out_ext[0][IW-1:0];
			rsp_q.point_y    <= out_ext[1][IW-1:0];
			rsp_q.point_z    <= out_ext[2][IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORNER_COUNT; k++) begin
				for (int a = 0; a < 3; a++) world_q[k][a] <= '0;
			end
		end else if (ctl.fin && !ctl.is_query) begin
			world_q[ctl.k][ctl.r] <= final_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.fin && ctl.is_query && ctl.k == CORNER_BITS'(CORNER_COUNT-1)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_data         = rsp_q;
	assign stat.rsp_pending = rsp_valid_q;

endmodule
`default_nettype wire

// ===== design/bsp_ctrl.sv =====
// controller: command decode and corner/row/axis sequencer
`timescale 1ns / 1ps
`default_nettype none
module bsp_ctrl import bsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [2:0] req_cmd,
	input  wire logic       rsp_ready,
	input  wire stat_t      stat,
	output logic            req_ready,
	output ctl_t            ctl
);

	localparam logic [CORNER_BITS-1:0] K_LAST = CORNER_BITS'(CORNER_COUNT-1);

	state_t                 state_q, state_d;
	logic [CORNER_BITS-1:0] k_q, k_d;
	logic [1:0]             r_q, r_d;
	logic [1:0]             i_q, i_d;
	logic                   query_q, query_d;
	logic                   fire;
	logic                   stall;

	assign fire  = req_valid && req_ready;
	assign stall = (state_q == ST_ACC) && query_q && (k_q == K_LAST)
		&& stat.rsp_pending && !rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		r_d     = r_q;
		i_d     = i_q;
		query_d = query_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire && (req_cmd == CMD_TRANSFORM || req_cmd == CMD_SUPPORT)) begin
					state_d = ST_MUL;
					k_d     = '0;
					r_d     = '0;
					i_d     = '0;
					query_d = (req_cmd == CMD_SUPPORT);
				end
			end
			ST_MUL: begin
				if (i_q == AXIS_LAST) begin
					state_d = ST_ACC;
				end else begin
					i_d = i_q + 2'd1;
				end
			end
			ST_ACC: begin
				if (!stall) begin
					i_d     = '0;
					state_d = ST_MUL;
					if (!query_q && r_q != ROW_LAST) begin
						r_d = r_q + 2'd1;
					end else if (k_q == K_LAST) begin
						state_d = ST_IDLE;
					end else begin
						r_d = '0;
						k_d = k_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = (state_q == ST_IDLE);
		ctl.load     = fire;
		ctl.mul_en   = (state_q == ST_MUL);
		ctl.acc_init = (state_q == ST_MUL) && (i_q == '0);
		ctl.fin      = (state_q == ST_ACC) && !stall;
		ctl.is_query = query_q;
		ctl.k        = k_q;
		ctl.r        = r_q;
		ctl.i        = i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			r_q     <= '0;
			i_q     <= '0;
			query_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			r_q     <= r_d;
			i_q     <= i_d;
			query_q <= query_d;
		end
	end

	a_acc_after_last_axis: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> i_q == AXIS_LAST)
		else $error("accumulate step reached before last axis");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> (r_q != 2'd3) && (!query_q || r_q == '0))
		else $error("row counter out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> state_q == ST_ACC && $stable(k_q))
		else $error("sequencer moved while result slot full");

	a_fin_not_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> !stall && !req_ready)
		else $error("writeback issued during stall or idle");

endmodule
`default_nettype wire

// ===== design/box_support_point_unit.sv =====
// top level: box support-point unit, controller plus datapath
//
//  channel | dir | payload                                 | transfer when
//  req     | in  | cmd, row_sel, val_a, val_b, val_c, val_d | req.valid && req.ready
//  rsp     | out | best_index, point_x, point_y, point_z    | rsp.valid && rsp.ready
//
// commands 0..3: the item is absorbed at its transfer
// command 4 walks 8 corners x 3 rows through one shared multiplier, with three
//   products plus writeback per row
// command 5 walks 8 corners, three products plus compare each, then the result sits
//   in an output register; new items are taken while it waits
// a query finishing while the previous result is still untaken holds in its
//   last step until the output register frees
// reset clears bounds to sentinels, corners to zero, matrix to identity
`timescale 1ns / 1ps
`default_nettype none
module box_support_point_unit import bsp_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input wire logic            clk,
	input wire logic            arst_n,
	bsp_stream_if.sink          req,
	bsp_stream_if.source        rsp
);

	ctl_t  ctl;
	stat_t stat;

	// sequencer
	bsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.data.cmd),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.req_ready (req.ready),
		.ctl       (ctl)
	);

	// storage, multiply-accumulate and result register
	bsp_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.ctl       (ctl),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data),
		.rsp_valid (rsp.valid),
		.stat      (stat)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: random and directed check of the box support-point unit against a local predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench import bsp_pkg::*; ();

	localparam int FB = FRAC_BITS_DEF;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;

	// predictor state, held at full precision
	class corner_predictor;
		longint bmin[3], bmax[3];
		longint lc[8][3], wc[8][3];
		longint mtx[12];
		rsp_t pending[$];
		int errors;

		function new();
			foreach (bmin[i]) begin
				bmin[i] = CMAX;
				bmax[i] = CMIN;
			end
			foreach (lc[k, i]) begin
				lc[k][i] = 0;
				wc[k][i] = 0;
			end
			foreach (mtx[i]) mtx[i] = 0;
			for (int i = 0; i < 3; i++) mtx[i*4+i] = longint'(1) << FB;
			errors = 0;
		endfunction

		function longint clamp(longint v);
			if (v > CMAX) return CMAX;
			if (v < CMIN) return CMIN;
			return v;
		endfunction

		// note one accepted transfer on the request side
		function void note_request(req_t q);
			longint v[4];
			logic [2:0] ax;
			logic signed [127:0] acc, dot, best_dot;
			int best;
			v[0] = q.val_a; v[1] = q.val_b; v[2] = q.val_c; v[3] = q.val_d;
			case (q.cmd)
				CMD_RESET_BOUNDS: for (int i = 0; i < 3; i++) begin
					bmin[i] = CMAX;
					bmax[i] = CMIN;
				end
				CMD_VERTEX: for (int i = 0; i < 3; i++) begin
					if (v[i] > bmax[i]) bmax[i] = v[i];
					if (v[i] < bmin[i]) bmin[i] = v[i];
				end
				CMD_BUILD: for (int i = 0; i < 3; i++) begin
					longint d, e;
					d = bmax[i] - bmin[i];
					e = clamp(bmin[i] + (d < 0 ? -d : d));
					for (int k = 0; k < 8; k++) begin
						ax = corner_axes(k[2:0]);
						lc[k][i] = ax[i] ? e : bmin[i];
					end
				end
				CMD_MATRIX_ROW: if (q.row_sel <= ROW_LAST)
					for (int i = 0; i < 4; i++) mtx[q.row_sel*4+i] = v[i];
				CMD_TRANSFORM: for (int k = 0; k < 8; k++)
					for (int r = 0; r < 3; r++) begin
						acc = mtx[r*4+3];
						for (int i = 0; i < 3; i++)
							acc += (128'(signed'(mtx[r*4+i])) * 128'(signed'(lc[k][i]))) >>> FB;
						if (acc > CMAX) wc[k][r] = CMAX;
						else if (acc < CMIN) wc[k][r] = CMIN;
						else wc[k][r] = longint'(acc);
					end
				CMD_SUPPORT: begin
					rsp_t e;
					best = 0;
					best_dot = 0;
					for (int k = 0; k < 8; k++) begin
						dot = 0;
						for (int i = 0; i < 3; i++)
							dot += 128'(signed'(wc[k][i])) * 128'(signed'(v[i]));
						if (k == 0 || dot > best_dot) begin
							best = k;
							best_dot = dot;
						end
					end
					e.best_index = best[2:0];
					e.point_x = wc[best][0][31:0];
					e.point_y = wc[best][1][31:0];
					e.point_z = wc[best][2][31:0];
					pending.push_back(e);
				end
				default: ;
			endcase
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result idx=%0d", $time, a.best_index);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.best_index !== e.best_index) begin
				$display("%0t: best_index exp %0d got %0d", $time, e.best_index, a.best_index);
				errors++;
			end
			if (a.point_x !== e.point_x) begin
				$display("%0t: point_x exp %0d got %0d", $time, e.point_x, a.point_x);
				errors++;
			end
			if (a.point_y !== e.point_y) begin
				$display("%0t: point_y exp %0d got %0d", $time, e.point_y, a.point_y);
				errors++;
			end
			if (a.point_z !== e.point_z) begin
				$display("%0t: point_z exp %0d got %0d", $time, e.point_z, a.point_z);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bsp_stream_if #(req_t) req_ch ();
	bsp_stream_if #(rsp_t) rsp_ch ();

	corner_predictor scb = new();
	bit hold_rsp = 1'b0;       // long receiver hold-off requested by stimulus
	int stall_mode = 0;

	box_support_point_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #5 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: stall pattern changes now and then; hold_rsp forces a long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) scb.check_result(rsp_ch.data);
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: rsp_ch.ready <= !hold_rsp;
				1: rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 3) != 0);
				2: rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= !hold_rsp && $urandom_range(0, 1);
			endcase
		end
	end

	int burst_left = 0;

	// one request transfer, with burst and gap idling in front of it
	task automatic send_request(req_t q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		scb.note_request(q);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (scb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 4) << 16;
			3: return $urandom_range(0, 1) ? -($urandom_range(1, 400) << 12)
				: ($urandom_range(1, 400) << 12);
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t make_req(logic [2:0] c, logic [1:0] r, logic [31:0] a,
			logic [31:0] b, logic [31:0] cc, logic [31:0] d);
		req_t q;
		q.cmd = c; q.row_sel = r; q.val_a = a; q.val_b = b; q.val_c = cc; q.val_d = d;
		return q;
	endfunction

	function automatic req_t rand_req(logic [2:0] c);
		return make_req(c, 2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
	endfunction

	localparam logic [31:0] ONE = 32'h00010000;

	initial begin
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		// query before any transform: all corners zero, tie keeps corner 0
		send_request(make_req(CMD_SUPPORT, '0, ONE, ONE, ONE, '0));
		// empty box build then transform and query
		send_request(make_req(CMD_BUILD, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_TRANSFORM, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_SUPPORT, '0, 32'hffff0000, '0, '0, '0));
		// extreme vertices, unused commands, row select three
		send_request(make_req(CMD_RESET_BOUNDS, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_VERTEX, '0, 32'h80000000, 32'h7fffffff, '0, '0));
		send_request(make_req(CMD_VERTEX, '0, 32'h7fffffff, 32'h80000000, 32'hffffffff, '0));
		send_request(make_req(3'd6, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff));
		send_request(make_req(3'd7, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_MATRIX_ROW, 2'd3, 32'h12345678, 32'd1, 32'd2, 32'd3));
		send_request(make_req(CMD_BUILD, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_MATRIX_ROW, 2'd0, 32'h7fffffff, 32'h80000000, ONE,
			32'h7fffffff));
		send_request(make_req(CMD_MATRIX_ROW, 2'd1, '0, ONE, '0, 32'h80000000));
		send_request(make_req(CMD_MATRIX_ROW, 2'd2, 32'hffff0000, '0, ONE, 32'h00008000));
		send_request(make_req(CMD_TRANSFORM, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_SUPPORT, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, '0));
		send_request(make_req(CMD_SUPPORT, '0, '0, '0, '0, '0));
		send_request(make_req(CMD_SUPPORT, '0, 32'h80000000, 32'h7fffffff, 32'h80000000, '0));
		// sender pause until everything has come back
		drain();

		n = 0;
		while (n < 450) begin
			if (n >= 200 && !held) begin
				// long receiver hold-off while queries keep coming
				held = 1'b1;
				hold_rsp = 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_rsp = 1'b0;
					end
				join_none
			end
			if ($urandom_range(0, 9) != 0) begin
				// well-formed sequence: bounds, vertices, build, rows, transform, queries
				send_request(rand_req(CMD_RESET_BOUNDS));
				repeat ($urandom_range(1, 4)) send_request(rand_req(CMD_VERTEX));
				send_request(rand_req(CMD_BUILD));
				for (int r = 0; r < 3; r++)
					if ($urandom_range(0, 1)) send_request(make_req(CMD_MATRIX_ROW, r[1:0],
						rand_coord(), rand_coord(), rand_coord(), rand_coord()));
				send_request(rand_req(CMD_TRANSFORM));
				repeat ($urandom_range(1, 3)) send_request(rand_req(CMD_SUPPORT));
				n += 8;
			end else begin
				send_request(rand_req(3'($urandom_range(0, 7))));
				n++;
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (scb.errors == 0 && scb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/bsp_pkg.sv
design/bsp_stream_if.sv
design/bsp_datapath.sv
design/bsp_ctrl.sv
design/box_support_point_unit.sv
tb/testbench.sv
